// ===== hw/rtl/rle4_pkg.sv =====
// ----------------------------------------------------------------------------
// rle4_pkg
// Shared types and constants of the RLE4 bitmap encoder.
// ----------------------------------------------------------------------------
package rle4_pkg;

    localparam int unsigned PIX_W       = 4;   // palette index
    localparam int unsigned BYTE_W      = 8;   // stream byte
    localparam int unsigned CFG_W       = 13;  // width/height registers
    localparam int unsigned CFG_IDX_W   = 1;   // register index
    localparam int unsigned QUEUE_DEPTH = 4;   // front-to-back command queue
    localparam int unsigned SLOT_N      = 8;   // bytes a command can expand to

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [BYTE_W-1:0] ESC_BYTE = 8'h00;  // escape lead byte
    localparam logic [BYTE_W-1:0] EOL_CODE = 8'h00;  // end of line
    localparam logic [BYTE_W-1:0] EOI_CODE = 8'h01;  // end of bitmap

    // One classified pixel: optional closed run, optional row end tail.
    typedef struct packed {
        logic              has_a;   // run closed by a color change / max length
        logic [BYTE_W-1:0] cnt_a;
        logic [PIX_W-1:0]  clr_a;
        logic              eol;     // row ends: run b closed, then 0,0
        logic [BYTE_W-1:0] cnt_b;
        logic [PIX_W-1:0]  clr_b;
        logic              eoi;     // image ends: 0,1 after the row end
    } t_cmd;

endpackage : rle4_pkg

// ===== hw/rtl/rle4_bitmap_encoder.sv =====
// ----------------------------------------------------------------------------
// rle4_bitmap_encoder
// RLE4 encoded-mode stream encoder for 4-bit palette pixels.
// ----------------------------------------------------------------------------
// Throughput: one pixel per cycle while the command queue has room; the
//   output side sends one byte per cycle unless stalled, so runs of short
//   runs back up. A pixel's results pass the queue, the back-end command
//   load and the back-end output register before the first byte shows.
// Reset: synchronous, active low; run state, counters and queue empty,
//   width and height return to 64.
//
// Structure:
//   front  - takes a pixel every cycle unless stalled, keeps the open run
//            and the column/row position, and for a pixel that closes a
//            run or a row writes one command: an optional closed run, and
//            for a row end the last run plus 0,0 and, at image end, 0,1.
//   queue  - QUEUE_DEPTH commands; the front stalls only when it is full.
//   back   - walks a command's byte mask lowest slot first, one byte a
//            cycle unless stalled, into the output register, last set on the final byte.
// ----------------------------------------------------------------------------
module rle4_bitmap_encoder import rle4_pkg::*; #(
    parameter int unsigned MAX_WIDTH  = 4096,
    parameter int unsigned MAX_HEIGHT = 4096,
    parameter int unsigned MAX_RUN    = 255
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration writes
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    // pixel items in
    input  logic                 i_pixel_valid,
    output logic                 o_pixel_stall,
    input  logic [PIX_W-1:0]     i_pixel,
    // byte items out
    output logic                 o_byte_valid,
    input  logic                 i_byte_stall,
    output logic [BYTE_W-1:0]    o_out_byte,
    output logic                 o_last
);

    logic [CFG_W-1:0] r_image_width;
    logic [CFG_W-1:0] r_image_height;

    t_cmd push_cmd, head_cmd;
    logic push, pop, q_full, q_empty;

    // size registers; the front clamps them to the legal range
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= CFG_W'(64);
            r_image_height <= CFG_W'(64);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data;
                REG_IMAGE_HEIGHT: r_image_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    rle4_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_RUN    (MAX_RUN)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_width  (r_image_width),
        .i_height (r_image_height),
        .i_valid  (i_pixel_valid),
        .i_pixel  (i_pixel),
        .o_stall  (o_pixel_stall),
        .i_full   (q_full),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    rle4_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_data  (head_cmd),
        .o_empty (q_empty)
    );

    rle4_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (head_cmd),
        .i_empty (q_empty),
        .o_pop   (pop),
        .o_valid (o_byte_valid),
        .o_byte  (o_out_byte),
        .o_last  (o_last),
        .i_stall (i_byte_stall)
    );

endmodule : rle4_bitmap_encoder

// ===== hw/rtl/rle4_queue.sv =====
// ----------------------------------------------------------------------------
// rle4_queue
// Small register FIFO of run commands between front and back.
// ----------------------------------------------------------------------------
module rle4_queue import rle4_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_data,
    output logic o_empty
);

    localparam int unsigned AW = $clog2(QUEUE_DEPTH);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [AW-1:0]     r_wr_ptr;
    logic [AW-1:0]     r_rd_ptr;
    logic [AW:0]       r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == (AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + (AW+1)'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - (AW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule : rle4_queue

// ===== hw/rtl/rle4_front.sv =====
// ----------------------------------------------------------------------------
// rle4_front
// Accepts pixels, tracks the open run and row/column position, and turns
// each pixel that closes something into one command for the queue.
// ----------------------------------------------------------------------------
module rle4_front import rle4_pkg::*; #(
    parameter int unsigned MAX_WIDTH  = 4096,
    parameter int unsigned MAX_HEIGHT = 4096,
    parameter int unsigned MAX_RUN    = 255
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CFG_W-1:0] i_width,
    input  logic [CFG_W-1:0] i_height,
    input  logic             i_valid,
    input  logic [PIX_W-1:0] i_pixel,
    output logic             o_stall,
    input  logic             i_full,
    output logic             o_push,
    output t_cmd             o_cmd
);

    localparam int unsigned CW  = $clog2(MAX_WIDTH);
    localparam int unsigned HW  = $clog2(MAX_HEIGHT);
    localparam int unsigned RW  = $clog2(MAX_RUN + 1);
    localparam int unsigned WCW = ($clog2(MAX_WIDTH + 1) > CFG_W) ?
                                  $clog2(MAX_WIDTH + 1) : CFG_W;
    localparam int unsigned HCW = ($clog2(MAX_HEIGHT + 1) > CFG_W) ?
                                  $clog2(MAX_HEIGHT + 1) : CFG_W;

    logic [PIX_W-1:0] r_run_color;
    logic [RW-1:0]    r_run_len;
    logic [CW-1:0]    r_col;
    logic [HW-1:0]    r_row;

    logic [WCW-1:0]   w_ext, w_eff, col_p1;
    logic [HCW-1:0]   h_ext, h_eff, row_p1;
    logic             cont, row_end, img_end, accept;
    logic [RW-1:0]    len1;

    // out-of-range sizes: zero acts as one, above max acts as max
    always_comb begin
        w_ext = WCW'(i_width);
        h_ext = HCW'(i_height);
        if (w_ext == '0) begin
            w_eff = WCW'(1);
        end else if (w_ext > WCW'(MAX_WIDTH)) begin
            w_eff = WCW'(MAX_WIDTH);
        end else begin
            w_eff = w_ext;
        end
        if (h_ext == '0) begin
            h_eff = HCW'(1);
        end else if (h_ext > HCW'(MAX_HEIGHT)) begin
            h_eff = HCW'(MAX_HEIGHT);
        end else begin
            h_eff = h_ext;
        end
    end

    assign col_p1  = WCW'(r_col) + WCW'(1);
    assign row_p1  = HCW'(r_row) + HCW'(1);
    assign row_end = (col_p1 >= w_eff);
    assign img_end = row_end && (row_p1 >= h_eff);

    assign cont = (r_run_len != '0) && (i_pixel == r_run_color) &&
                  (r_run_len < RW'(MAX_RUN));
    assign len1 = cont ? (r_run_len + RW'(1)) : RW'(1);

    always_comb begin
        o_cmd.has_a = !cont && (r_run_len != '0);
        o_cmd.cnt_a = BYTE_W'(r_run_len);
        o_cmd.clr_a = r_run_color;
        o_cmd.eol   = row_end;
        o_cmd.cnt_b = BYTE_W'(len1);
        o_cmd.clr_b = i_pixel;   // equals run color when the run goes on
        o_cmd.eoi   = img_end;
    end

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;
    assign o_push  = accept && (o_cmd.has_a || row_end);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_color <= '0;
            r_run_len   <= '0;
            r_col       <= '0;
            r_row       <= '0;
        end else if (accept) begin
            r_run_color <= i_pixel;
            if (row_end) begin
                r_run_len <= '0;
                r_col     <= '0;
                r_row     <= img_end ? '0 : row_p1[HW-1:0];
            end else begin
                r_run_len <= len1;
                r_col     <= col_p1[CW-1:0];
            end
        end
    end

endmodule : rle4_front

// ===== hw/rtl/rle4_back.sv =====
// ----------------------------------------------------------------------------
// rle4_back
// Expands queued commands into stream bytes, one per cycle while the
// output is not stalled, into an output register.
// ----------------------------------------------------------------------------
module rle4_back import rle4_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic              i_empty,
    output logic              o_pop,
    output logic              o_valid,
    output logic [BYTE_W-1:0] o_byte,
    output logic              o_last,
    input  logic              i_stall
);

    t_cmd              r_cmd;
    logic [SLOT_N-1:0] r_mask;     // bytes still to send, slot 0 first
    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              r_last;

    logic              out_free, emit, mask_done;
    logic [SLOT_N-1:0] low, rest;
    logic [BYTE_W-1:0] slot_byte [SLOT_N];
    logic [BYTE_W-1:0] sel_byte;

    // slots: count a, pair a, count b, pair b, 0, 0, 0, 1
    always_comb begin
        slot_byte[0] = r_cmd.cnt_a;
        slot_byte[1] = {r_cmd.clr_a, r_cmd.clr_a};
        slot_byte[2] = r_cmd.cnt_b;
        slot_byte[3] = {r_cmd.clr_b, r_cmd.clr_b};
        slot_byte[4] = ESC_BYTE;
        slot_byte[5] = EOL_CODE;
        slot_byte[6] = ESC_BYTE;
        slot_byte[7] = EOI_CODE;
    end

    assign low  = r_mask & (~r_mask + SLOT_N'(1));
    assign rest = r_mask & ~low;

    always_comb begin
        sel_byte = '0;
        for (int i = 0; i < SLOT_N; i++) begin
            sel_byte = sel_byte | (slot_byte[i] & {BYTE_W{low[i]}});
        end
    end

    assign out_free  = !r_valid || !i_stall;
    assign emit      = out_free && (r_mask != '0);
    assign mask_done = (r_mask == '0) || (emit && (rest == '0));
    assign o_pop     = mask_done && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_mask <= {i_cmd.eoi, i_cmd.eoi, i_cmd.eol, i_cmd.eol,
                           i_cmd.eol, i_cmd.eol, i_cmd.has_a, i_cmd.has_a};
            end else if (emit) begin
                r_mask <= rest;
            end
            if (emit) begin
                r_valid <= 1'b1;
            end else if (out_free) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        if (emit) begin
            r_byte <= sel_byte;
            r_last <= (rest == '0);
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_last  = r_last;

endmodule : rle4_back

// ===== hw/rtl/rle4_checker.sv =====
// ----------------------------------------------------------------------------
// rle4_checker
// Port-level checks of the RLE4 encoder, bound to the top level.
// ----------------------------------------------------------------------------
module rle4_checker import rle4_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_pixel_stall,
    input logic              o_byte_valid,
    input logic              i_byte_stall,
    input logic [BYTE_W-1:0] o_out_byte,
    input logic              o_last
);

    // a stalled byte holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_byte_valid && i_byte_stall |=>
            o_byte_valid && $stable(o_out_byte) && $stable(o_last))
        else $error("stalled output byte changed");

    // bytes of one pixel's results go out without gaps
    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_byte_valid && !i_byte_stall && !o_last |=> o_byte_valid)
        else $error("gap inside a result burst");

    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_byte_valid)
        else $error("output valid after reset");

    a_rst_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_pixel_stall)
        else $error("input stalled after reset");

endmodule : rle4_checker

bind rle4_bitmap_encoder rle4_checker u_rle4_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_pixel_stall (o_pixel_stall),
    .o_byte_valid  (o_byte_valid),
    .i_byte_stall  (i_byte_stall),
    .o_out_byte    (o_out_byte),
    .o_last        (o_last)
);
